@@ rtl/nhrc_pkg.sv @@
// ----------------------------------------------------------------------------
// Near-homopolymer read classifier package
// Shared widths, register indexes, base codes and result kinds.
// ----------------------------------------------------------------------------
package nhrc_pkg;

  localparam int READ_LEN_DEF = 1024;

  localparam int BASE_W  = 2;
  localparam int KIND_W  = 2;
  localparam int CNT_W   = 11;
  localparam int LEN_W   = 11;
  localparam int THR_W   = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;

  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  localparam logic [BASE_W-1:0] BASE_A = 2'd0;
  localparam logic [BASE_W-1:0] BASE_T = 2'd3;

  localparam logic [KIND_W-1:0] KIND_NONE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_A    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_T    = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_DIFF_THRESHOLD  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ENCODED_LEN = 1'd1;

endpackage

@@ rtl/nhrc_in_if.sv @@
// ----------------------------------------------------------------------------
// Base input channel
// Valid/ready channel that carries one base of a read per transfer.
// ----------------------------------------------------------------------------
interface nhrc_in_if;
  logic                         valid;
  logic                         ready;
  logic [nhrc_pkg::BASE_W-1:0]  base;
  logic                         is_unknown;
  logic                         last;

  modport source (output valid, base, is_unknown, last, input ready);
  modport sink   (input valid, base, is_unknown, last, output ready);
endinterface

@@ rtl/nhrc_out_if.sv @@
// ----------------------------------------------------------------------------
// Classification result channel
// Valid/ready channel that carries one read classification per transfer.
// ----------------------------------------------------------------------------
interface nhrc_out_if;
  logic                         valid;
  logic                         ready;
  logic [nhrc_pkg::KIND_W-1:0]  kind;
  logic [nhrc_pkg::LEN_W-1:0]   encoded_len;

  modport source (output valid, kind, encoded_len, input ready);
  modport sink   (input valid, kind, encoded_len, output ready);
endinterface

@@ rtl/near_homopolymer_read_classifier_core.sv @@
// ----------------------------------------------------------------------------
// Near-homopolymer read classifier core
// Streams a read one base per transfer on in_ch and, on the last base,
// sends one classification on out_ch: near all-A, near all-T or neither,
// with the run-length encoded length of the chosen kind (the A length for neither).
//
// Two registers are loaded through the write port (cfg_we, cfg_index,
// cfg_wdata): the differing-bit threshold and the encoded length limit.
// They must be written only while no read is in flight.
//
// One base is taken every cycle while no last base waits for the output
// register. A base is held in the input register, then the counters update
// as it leaves; the output register is loaded as the last base of a read
// leaves the input register. The output register frees itself in the same
// cycle it is taken, so a result can follow every cycle. When the receiver
// stalls, non-last bases keep flowing; a last base waits in the input
// register until the output register is free, and the input stalls behind it.
//
// Reset clears the counters, both registers and both valid flags.
// ----------------------------------------------------------------------------
module near_homopolymer_read_classifier_core #(
  parameter int READ_LEN = nhrc_pkg::READ_LEN_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [nhrc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nhrc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  nhrc_in_if.sink                         in_ch,
  nhrc_out_if.source                      out_ch
);
  import nhrc_pkg::*;

  localparam int RUN_W = $clog2(READ_LEN + 1);
  localparam logic [RUN_W-1:0] RUN_MAX = RUN_W'(READ_LEN);
  localparam int SUM_W = LEN_W + 2;

  logic [THR_W-1:0] diff_threshold;
  logic [LEN_W-1:0] max_encoded_len;

  logic              s1_valid;
  logic [BASE_W-1:0] s1_base;
  logic              s1_unknown;
  logic              s1_last;

  logic [CNT_W-1:0] bits_off_a, bits_off_t;
  logic [RUN_W-1:0] run_of_a, run_of_t;
  logic [LEN_W-1:0] len_vs_a, len_vs_t;

  logic [CNT_W-1:0] bits_off_a_next, bits_off_t_next;
  logic [RUN_W-1:0] run_of_a_next, run_of_t_next;
  logic [LEN_W-1:0] len_vs_a_next, len_vs_t_next;

  logic              out_valid;
  logic [KIND_W-1:0] kind;
  logic [LEN_W-1:0]  encoded_len;
  logic [KIND_W-1:0] kind_next;
  logic [LEN_W-1:0]  encoded_len_next;

  logic out_free, s1_go;
  logic [1:0] ones;
  logic is_a, is_t;
  logic [LEN_W-1:0] fin_a, fin_t;

  function automatic logic [2:0] digit_count(input logic [RUN_W-1:0] n);
    logic [2:0] d;
    if (32'(n) >= 32'd1000) d = 3'd4;
    else if (32'(n) >= 32'd100) d = 3'd3;
    else if (32'(n) >= 32'd10) d = 3'd2;
    else d = 3'd1;
    return d;
  endfunction

  function automatic logic [LEN_W-1:0] len_step(input logic [LEN_W-1:0] len,
                                                input logic [RUN_W-1:0] run);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(len) + SUM_W'(1);
    if (run != '0) sum = sum + SUM_W'(digit_count(run));
    if (sum > SUM_W'(CNT_MAX)) sum = SUM_W'(CNT_MAX);
    return sum[LEN_W-1:0];
  endfunction

  function automatic logic [CNT_W-1:0] cnt_add(input logic [CNT_W-1:0] c,
                                               input logic [1:0] v);
    logic [CNT_W:0] sum;
    sum = {1'b0, c} + (CNT_W + 1)'(v);
    if (sum > (CNT_W + 1)'(CNT_MAX)) sum = (CNT_W + 1)'(CNT_MAX);
    return sum[CNT_W-1:0];
  endfunction

  assign out_free    = !out_valid || out_ch.ready;
  assign s1_go       = s1_valid && (!s1_last || out_free);
  assign in_ch.ready = !s1_valid || s1_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      diff_threshold  <= '0;
      max_encoded_len <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DIFF_THRESHOLD:  diff_threshold  <= cfg_wdata[THR_W-1:0];
        CFG_MAX_ENCODED_LEN: max_encoded_len <= cfg_wdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_base    <= in_ch.base;
      s1_unknown <= in_ch.is_unknown;
      s1_last    <= in_ch.last;
    end
  end

  always_comb begin
    ones = {1'b0, s1_base[0]} + {1'b0, s1_base[1]};
    is_a = !s1_unknown && (s1_base == BASE_A);
    is_t = !s1_unknown && (s1_base == BASE_T);

    bits_off_a_next = cnt_add(bits_off_a, ones);
    bits_off_t_next = cnt_add(bits_off_t, 2'd2 - ones);

    if (is_a) begin
      run_of_a_next = (run_of_a < RUN_MAX) ? run_of_a + RUN_W'(1) : run_of_a;
      len_vs_a_next = len_vs_a;
    end else begin
      run_of_a_next = '0;
      len_vs_a_next = len_step(len_vs_a, run_of_a);
    end

    if (is_t) begin
      run_of_t_next = (run_of_t < RUN_MAX) ? run_of_t + RUN_W'(1) : run_of_t;
      len_vs_t_next = len_vs_t;
    end else begin
      run_of_t_next = '0;
      len_vs_t_next = len_step(len_vs_t, run_of_t);
    end

    fin_a = (len_vs_a_next == '0) ? LEN_W'(1) : len_vs_a_next;
    fin_t = (len_vs_t_next == '0) ? LEN_W'(1) : len_vs_t_next;

    kind_next        = KIND_NONE;
    encoded_len_next = fin_a;
    if ({1'b0, bits_off_a_next} <= diff_threshold) begin
      if (fin_a <= max_encoded_len) kind_next = KIND_A;
    end else if ({1'b0, bits_off_t_next} <= diff_threshold) begin
      if (fin_t <= max_encoded_len) begin
        kind_next        = KIND_T;
        encoded_len_next = fin_t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bits_off_a <= '0;
      bits_off_t <= '0;
      run_of_a   <= '0;
      run_of_t   <= '0;
      len_vs_a   <= '0;
      len_vs_t   <= '0;
    end else if (s1_go) begin
      if (s1_last) begin
        bits_off_a <= '0;
        bits_off_t <= '0;
        run_of_a   <= '0;
        run_of_t   <= '0;
        len_vs_a   <= '0;
        len_vs_t   <= '0;
      end else begin
        bits_off_a <= bits_off_a_next;
        bits_off_t <= bits_off_t_next;
        run_of_a   <= run_of_a_next;
        run_of_t   <= run_of_t_next;
        len_vs_a   <= len_vs_a_next;
        len_vs_t   <= len_vs_t_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go && s1_last) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_last) begin
      kind        <= kind_next;
      encoded_len <= encoded_len_next;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.kind        = kind;
  assign out_ch.encoded_len = encoded_len;

  // A finished read leaves every counter cleared for the next one.
  assert property (@(posedge clk) disable iff (rst)
    s1_go && s1_last |=> bits_off_a == '0 && bits_off_t == '0 &&
                         len_vs_a == '0 && len_vs_t == '0)
    else $error("read counters not cleared after last base");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> encoded_len != '0 && kind <= KIND_T)
    else $error("malformed classification result");

  assert property (@(posedge clk) disable iff (rst)
    out_valid && kind != KIND_NONE |-> encoded_len <= max_encoded_len)
    else $error("accepted kind exceeds encoded length limit");

  assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_last && !out_free |=> s1_valid && s1_last)
    else $error("last base dropped while output was full");

endmodule
